FILE: hw/rtl/ole_pkg.sv
// ole_pkg: shared types for the ordered list engine
// operation codes, controller states and the command bus broadcast to the cell chain
// no dependencies
package ole_pkg;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_APPEND    = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_RM_FRONT  = 3'd3,
        MODE_RM_END    = 3'd4,
        MODE_RM_VAL    = 3'd5,
        MODE_READ      = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // command seen by every cell in the chain
    typedef struct packed {
        t_mode       mode;
        logic        commit;
        logic [31:0] value;
        logic [4:0]  pos;
    } t_cell_cmd;

endpackage

FILE: hw/rtl/ole_cell.sv
// ole_cell: one storage cell of the list chain
// holds one entry, a prefix match flag and a read pipeline stage; uses ole_pkg
module ole_cell
    import ole_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                           i_clk,
    input  t_cell_cmd                      i_cmd,
    input  logic [$clog2(DEPTH+1)-1:0]     i_len,
    input  logic [31:0]                    i_left,
    input  logic [31:0]                    i_right,
    input  logic                           i_seen_prev,
    input  logic [31:0]                    i_rd_next,
    output logic [31:0]                    o_entry,
    output logic                           o_hit,
    output logic [31:0]                    o_rd
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 5) ? LW : 5;

    logic [31:0]   r_entry;
    logic [31:0]   n_entry;
    logic          r_seen;
    logic [31:0]   r_rd;
    logic [CW-1:0] w_idx;
    logic [CW-1:0] w_pos;
    logic          w_live;
    logic          w_match;

    assign w_idx   = CW'(IDX);
    assign w_pos   = CW'(i_cmd.pos);
    assign w_live  = LW'(IDX) < i_len;
    assign w_match = w_live && (r_entry == i_cmd.value);
    // some cell at or below this one holds the value
    assign o_hit   = r_seen | w_match;
    assign o_entry = r_entry;
    assign o_rd    = r_rd;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.commit) begin
            unique case (i_cmd.mode)
                MODE_INS_FRONT: begin
                    n_entry = (IDX == 0) ? i_cmd.value : i_left;
                end
                MODE_APPEND: begin
                    if (LW'(IDX) == i_len) begin
                        n_entry = i_cmd.value;
                    end
                end
                MODE_INS_POS: begin
                    if (w_idx == w_pos) begin
                        n_entry = i_cmd.value;
                    end else if (w_idx > w_pos) begin
                        n_entry = i_left;
                    end
                end
                MODE_RM_FRONT: begin
                    n_entry = i_right;
                end
                MODE_RM_VAL: begin
                    if (o_hit) begin
                        n_entry = i_right;
                    end
                end
                default: begin
                    n_entry = r_entry;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_seen  <= i_seen_prev;
        r_rd    <= (w_idx == w_pos) ? r_entry : i_rd_next;
    end

endmodule

FILE: hw/rtl/ordered_list_engine_core.sv
// ordered_list_engine_core: bounded ordered list of signed 32-bit values
// top level; builds a chain of ole_cell instances, uses ole_pkg
//
// usage
//   command channel: drive i_mode, i_value, i_position with start high; the item
//   is taken at a rising edge where start is high and busy is low
//   result channel: o_valid is high for exactly one cycle with o_ok, o_read_data
//   and o_count; the receiver cannot hold results off, so it must sample them then
// timing
//   insert front, append, insert at position, remove front, remove end and the
//   unused code run straight from the command ports in the cycle they are taken;
//   the result shows in the next cycle and busy stays low, so one item per cycle
//   while no remove value or read runs; those two scan the chain: the match flag
//   walks up the cell chain and the read data walks down it, one cell per cycle,
//   through the scan state, then the finish state applies the removal or picks up
//   the data; busy is high the whole time and falls in the cycle the result shows
// reset
//   synchronous, active low; the list is emptied (count zero) and no result is
//   shown; stored entries are not cleared, only positions below count are used
module ordered_list_engine_core
    import ole_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [4:0]  i_position,
    output logic        o_valid,
    output logic        o_ok,
    output logic [31:0] o_read_data,
    output logic [4:0]  o_count
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 5) ? LW : 5;
    localparam int SW = $clog2(DEPTH);

    // controller state
    t_state       r_state;
    t_state       n_state;
    logic [SW-1:0] r_scan;
    logic [SW-1:0] n_scan;
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;

    // latched command for the multi-cycle operations
    t_mode        r_mode;
    logic [31:0]  r_value;
    logic [4:0]   r_pos;

    // command as seen this cycle
    t_mode        w_mode;
    logic [31:0]  w_value;
    logic [4:0]   w_pos;
    logic         w_accept;
    logic         w_long;
    logic         w_exec;
    logic         w_ok;
    logic [31:0]  w_data;
    logic         w_full;
    logic         w_empty;
    logic         w_pos_in;
    t_cell_cmd    w_cmd;

    // chain links
    logic [31:0]  w_entry [DEPTH];
    logic         w_hit   [DEPTH];
    logic [31:0]  w_rd    [DEPTH];

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_long   = (t_mode'(i_mode) == MODE_RM_VAL) || (t_mode'(i_mode) == MODE_READ);

    // idle: act on the ports; otherwise on the held command
    assign w_mode  = (r_state == ST_IDLE) ? t_mode'(i_mode) : r_mode;
    assign w_value = (r_state == ST_IDLE) ? i_value : r_value;
    assign w_pos   = (r_state == ST_IDLE) ? i_position : r_pos;

    assign w_exec   = (w_accept && !w_long) || (r_state == ST_FIN);
    assign w_full   = (r_len == LW'(DEPTH));
    assign w_empty  = (r_len == '0);
    assign w_pos_in = CW'(w_pos) < CW'(r_len);

    // outcome of the operation and the new length
    always_comb begin
        w_ok   = 1'b0;
        w_data = '0;
        n_len  = r_len;
        unique case (w_mode)
            MODE_INS_FRONT, MODE_APPEND: begin
                w_ok = !w_full;
            end
            MODE_INS_POS: begin
                w_ok = !w_full && ((w_pos == '0) || w_pos_in);
            end
            MODE_RM_FRONT, MODE_RM_END: begin
                w_ok = !w_empty;
            end
            MODE_RM_VAL: begin
                w_ok = w_hit[DEPTH-1];
            end
            MODE_READ: begin
                w_ok   = w_pos_in;
                w_data = w_pos_in ? w_rd[0] : '1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        if (w_exec && w_ok) begin
            unique case (w_mode)
                MODE_INS_FRONT, MODE_APPEND, MODE_INS_POS: n_len = r_len + 1'b1;
                MODE_RM_FRONT, MODE_RM_END, MODE_RM_VAL:   n_len = r_len - 1'b1;
                default:                                   n_len = r_len;
            endcase
        end
    end

    assign w_cmd.mode   = w_mode;
    assign w_cmd.commit = w_exec && w_ok;
    assign w_cmd.value  = w_value;
    assign w_cmd.pos    = w_pos;

    // next state
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        unique case (r_state)
            ST_IDLE: begin
                n_scan = '0;
                if (w_accept && w_long) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_scan = r_scan + 1'b1;
                if (r_scan == SW'(DEPTH - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scan  <= '0;
            r_len   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_len   <= n_len;
            o_valid <= w_exec;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (w_exec) begin
            o_ok        <= w_ok;
            o_read_data <= w_data;
            o_count     <= 5'(n_len);
        end
    end

    // the cell chain: entry i sits in cell i
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        logic        w_seen_prev;
        logic [31:0] w_rd_next;

        if (g == 0) begin : g_first
            assign w_left      = w_value;
            assign w_seen_prev = 1'b0;
        end else begin : g_inner_lo
            assign w_left      = w_entry[g-1];
            assign w_seen_prev = w_hit[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right   = w_entry[g];
            assign w_rd_next = '0;
        end else begin : g_inner_hi
            assign w_right   = w_entry[g+1];
            assign w_rd_next = w_rd[g+1];
        end

        ole_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_len       (r_len),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_seen_prev (w_seen_prev),
            .i_rd_next   (w_rd_next),
            .o_entry     (w_entry[g]),
            .o_hit       (w_hit[g]),
            .o_rd        (w_rd[g])
        );
    end

endmodule

FILE: hw/rtl/ole_checker.sv
// ole_checker: port-level checks for ordered_list_engine_core
// bound to the top level below; uses ole_pkg
module ole_port_checks
    import ole_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] i_mode,
    input logic       o_valid
);

    logic w_long_cmd;

    // remove value and read walk the chain
    assign w_long_cmd = (t_mode'(i_mode) == MODE_RM_VAL) || (t_mode'(i_mode) == MODE_READ);

    // operations other than remove value and read answer in the next cycle
    a_short_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !w_long_cmd) |=> o_valid)
        else $error("single-cycle item gave no result");

    // scanning operations hold the command side off
    a_long_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_long_cmd) |=> (busy && !o_valid))
        else $error("scanning item did not raise busy");

    // busy only drops together with the result
    a_busy_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // reset leaves nothing pending
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("result or busy after reset");

endmodule

bind ordered_list_engine_core ole_port_checks u_ole_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_mode  (i_mode),
    .o_valid (o_valid)
);
